// ===== rtl/wlk_pkg.sv =====
package wlk_pkg;

  // fixed widths of the configuration registers and of the word fields
  localparam int RANK_W    = 3;
  localparam int SIZES_W   = 48;
  localparam int STRIDES_W = 64;
  localparam int BASE_W    = 32;
  localparam int OFS_W     = 49;
  localparam int SPOS_W    = 34;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANK      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SBASE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DBASE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd5;

  // per-step control handed from the top level to every cell
  typedef struct packed {
    logic accept;   // step word taken this cycle
    logic restart;  // restart bit of that word
    logic emit;     // this step gives an address pair
    logic en1;      // first pipeline stage loads
    logic en2;      // second pipeline stage loads
  } wlk_ctl_t;

endpackage

// ===== rtl/wlk_step_if.sv =====
interface wlk_step_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// ===== rtl/wlk_result_if.sv =====
interface wlk_result_if
  import wlk_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             valid_res;
  logic [OFS_W-1:0] read_offset;
  logic [OFS_W-1:0] write_offset;
  logic             last;

  modport source (output valid, output valid_res, output read_offset,
                  output write_offset, output last, input ready);
  modport sink (input valid, input valid_res, input read_offset,
                input write_offset, input last, output ready);
endinterface

// ===== rtl/wlk_cell.sv =====
module wlk_cell
  import wlk_pkg::*;
#(
  parameter int SIZE_BITS   = 12,
  parameter int STRIDE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wlk_ctl_t                         ctl,
  input  logic [SIZE_BITS-1:0]             size,
  input  logic [STRIDE_BITS-1:0]           stride,
  input  logic                             active,
  input  logic                             carry_in,
  output logic                             carry_out,
  output logic                             zero_size,
  output logic [SIZE_BITS+STRIDE_BITS-1:0] prod
);

  localparam int PROD_W = SIZE_BITS + STRIDE_BITS;

  logic [SIZE_BITS-1:0] idx;
  logic [SIZE_BITS-1:0] idx_eff;
  logic [SIZE_BITS-1:0] idx_inc;
  logic [SIZE_BITS-1:0] idx_next;
  logic [SIZE_BITS-1:0] idx1;
  logic                 wrap;

  // odometer digit: increment on carry, wrap at or past the size
  always_comb begin
    idx_eff  = ctl.restart ? '0 : idx;
    idx_inc  = idx_eff + SIZE_BITS'(1);
    wrap     = (idx_inc == '0) || (idx_inc >= size);
    idx_next = idx_eff;
    if (ctl.emit && active && carry_in) begin
      idx_next = wrap ? '0 : idx_inc;
    end
  end

  // an inactive axis passes the carry straight on
  assign carry_out = active ? (carry_in & wrap) : carry_in;
  assign zero_size = active && (size == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.accept) begin
      idx <= idx_next;
    end
  end

  // index snapshot, then index * stride one stage later
  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      idx1 <= idx_eff;
    end
    if (ctl.en2) begin
      prod <= active ? (PROD_W'(idx1) * PROD_W'(stride)) : '0;
    end
  end

endmodule

// ===== rtl/strided_nd_address_walker_core.sv =====
// Strided N-d address walker.
// Configure over the write port (wr_en, wr_index, wr_data) while idle: rank,
// axis sizes, axis strides, both bases and the direction. Each word taken on
// the step channel (valid and ready high) gives exactly one word on the
// result channel: an address pair with valid_res set, or valid_res clear with
// zero offsets once the walk is done or empty. restart=1 starts a new walk and
// emits its first element in the same word.
// Step words pass the index snapshot, multiply and sum stages and the output
// register; one is taken every cycle while step ready is high. The axis
// odometer is a chain of cells, one per axis, whose carry ripples
// combinationally from the innermost active axis outward; the strided offset
// goes through a multiply stage per cell, a sum stage and an add-and-select output register.
// When the receiver stalls, words fill the stages up to the output register
// and step ready drops only when every stage holds a word.
// Reset (rst, synchronous) zeroes the configuration, stage valids and indices
// and marks the walk done, so steps give empty words until a restart.
module strided_nd_address_walker_core
  import wlk_pkg::*;
#(
  parameter int MAX_RANK    = 4,
  parameter int SIZE_BITS   = 12,
  parameter int STRIDE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  wlk_step_if.sink             step,
  wlk_result_if.source         result
);

  localparam int PROD_W = SIZE_BITS + STRIDE_BITS;

  // configuration registers
  logic [RANK_W-1:0]    rank;
  logic [SIZES_W-1:0]   axis_sizes;
  logic [STRIDES_W-1:0] axis_strides;
  logic [BASE_W-1:0]    strided_base;
  logic [BASE_W-1:0]    dense_base;
  logic                 direction;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank         <= '0;
      axis_sizes   <= '0;
      axis_strides <= '0;
      strided_base <= '0;
      dense_base   <= '0;
      direction    <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_RANK:      rank         <= wr_data[RANK_W-1:0];
        CFG_SIZES:     axis_sizes   <= wr_data[SIZES_W-1:0];
        CFG_STRIDES:   axis_strides <= wr_data[STRIDES_W-1:0];
        CFG_SBASE:     strided_base <= wr_data[BASE_W-1:0];
        CFG_DBASE:     dense_base   <= wr_data[BASE_W-1:0];
        CFG_DIRECTION: direction    <= wr_data[0];
        default: ;
      endcase
    end
  end

  // walk state
  logic             walk_done;
  logic [OFS_W-1:0] dpos;
  logic [OFS_W-1:0] dpos_eff;
  logic             done_eff;
  logic             accept;

  // pipeline stage registers
  logic              v1, v2, v3, ov;
  logic              emit1, emit2, emit3;
  logic              last1, last2, last3;
  logic [OFS_W-1:0]  dpos1, doff2, doff3;
  logic [SPOS_W-1:0] spos3;
  logic              en1, en2, en3, en_o;

  logic [MAX_RANK:0]   carry;
  logic [MAX_RANK-1:0] zero;
  logic [PROD_W-1:0]   prod [MAX_RANK];
  wlk_ctl_t            ctl;

  // stage enables: a stage loads when empty or when it is moving on
  assign en_o = !ov || result.ready;
  assign en3  = !v3 || en_o;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;

  assign step.ready = en1;
  assign accept     = step.valid && en1;

  assign done_eff = (step.restart ? 1'b0 : walk_done) || (|zero);
  assign dpos_eff = step.restart ? '0 : dpos;

  assign ctl.accept  = accept;
  assign ctl.restart = step.restart;
  assign ctl.emit    = !done_eff;
  assign ctl.en1     = en1;
  assign ctl.en2     = en2;

  // innermost cell gets the step increment
  assign carry[MAX_RANK] = 1'b1;

  // chain of axis cells, axis 0 outermost
  for (genvar i = 0; i < MAX_RANK; i++) begin : g_axis
    localparam int SZ_SH = (MAX_RANK - 1 - i) * SIZE_BITS;
    localparam int ST_SH = (MAX_RANK - 1 - i) * STRIDE_BITS;
    logic [SIZE_BITS-1:0]   size_f;
    logic [STRIDE_BITS-1:0] stride_f;
    logic                   active;

    if (SZ_SH < SIZES_W) begin : g_size
      assign size_f = SIZE_BITS'(axis_sizes >> SZ_SH);
    end else begin : g_size_none
      assign size_f = '0;
    end
    if (ST_SH < STRIDES_W) begin : g_stride
      assign stride_f = STRIDE_BITS'(axis_strides >> ST_SH);
    end else begin : g_stride_none
      assign stride_f = '0;
    end

    // a rank above the cell count leaves every cell active
    assign active = (32'(rank) > i);

    wlk_cell #(
      .SIZE_BITS   (SIZE_BITS),
      .STRIDE_BITS (STRIDE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .size      (size_f),
      .stride    (stride_f),
      .active    (active),
      .carry_in  (carry[i+1]),
      .carry_out (carry[i]),
      .zero_size (zero[i]),
      .prod      (prod[i])
    );
  end

  // walk state update on each taken step
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_done <= 1'b1;
      dpos      <= '0;
    end else if (accept) begin
      walk_done <= done_eff ? 1'b1 : carry[0];
      dpos      <= done_eff ? dpos_eff : dpos_eff + OFS_W'(1);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (en1) v1 <= step.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en_o) ov <= v3;
    end
  end

  // sum of the per-axis products
  logic [SPOS_W-1:0] spos_sum;
  always_comb begin
    spos_sum = '0;
    for (int k = 0; k < MAX_RANK; k++) begin
      spos_sum = spos_sum + SPOS_W'(prod[k]);
    end
  end

  logic [OFS_W-1:0] soff;
  assign soff = OFS_W'(strided_base) + OFS_W'(spos3);

  // payload stages
  always_ff @(posedge clk) begin
    if (en1) begin
      emit1 <= !done_eff;
      last1 <= !done_eff && carry[0];
      dpos1 <= dpos_eff;
    end
    if (en2) begin
      emit2 <= emit1;
      last2 <= last1;
      doff2 <= OFS_W'(dense_base) + dpos1;
    end
    if (en3) begin
      emit3 <= emit2;
      last3 <= last2;
      doff3 <= doff2;
      spos3 <= spos_sum;
    end
    if (en_o) begin
      result.valid_res    <= emit3;
      result.last         <= last3;
      result.read_offset  <= emit3 ? (direction ? doff3 : soff) : '0;
      result.write_offset <= emit3 ? (direction ? soff : doff3) : '0;
    end
  end

  assign result.valid = ov;

endmodule
